[sv/cft_pkg.sv]
// Shared types, constants and the per-byte tokenizer step for the CSV field tokenizer.
package cft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] SEP_RESET = 8'h2c;

  // Depth of the result queue; it must hold the two results of one byte.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_EOF   = 3'd1,
    KIND_EOR   = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_ERR   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    Q_OUT  = 2'd0,
    Q_IN   = 2'd1,
    Q_HELD = 2'd2
  } qmode_e;

  typedef struct packed {
    qmode_e qm;
    logic   cont;
    logic   lhb;
  } tok_state_t;

  typedef struct packed {
    tok_state_t  st;
    logic        ev;
    kind_e       kind;
    logic [7:0]  data;
  } take_res_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // One byte through the quoting rules; the quote state is already normalized.
  function automatic take_res_t take_byte(tok_state_t s, logic [7:0] b, logic [7:0] sep);
    take_res_t r;
    logic      stop;
    r.st   = s;
    r.ev   = 1'b0;
    r.kind = KIND_DATA;
    r.data = 8'h00;
    stop   = 1'b0;
    if (s.qm == Q_HELD) begin
      if (b == CH_QUOTE) begin
        r.ev    = 1'b1;
        r.data  = CH_QUOTE;
        r.st.qm = Q_IN;
        stop    = 1'b1;
      end else begin
        r.st.qm = Q_OUT;
      end
    end
    if (!stop) begin
      if (r.st.qm == Q_IN) begin
        r.st.lhb = 1'b1;
        if (b == CH_QUOTE) begin
          r.st.qm = Q_HELD;
        end else begin
          if (b == CH_LF) begin
            r.st.cont = 1'b1;
          end
          r.ev   = 1'b1;
          r.data = b;
        end
      end else if (b == CH_LF) begin
        r.ev      = 1'b1;
        r.kind    = (s.lhb || s.cont) ? KIND_EOR : KIND_EMPTY;
        r.st.qm   = Q_OUT;
        r.st.cont = 1'b0;
        r.st.lhb  = 1'b0;
      end else begin
        r.st.lhb = 1'b1;
        if (b == CH_QUOTE) begin
          r.st.qm = Q_IN;
        end else if (b == sep) begin
          r.ev   = 1'b1;
          r.kind = KIND_EOF;
        end else begin
          r.ev   = 1'b1;
          r.data = b;
        end
      end
    end
    return r;
  endfunction

endpackage

[sv/cft_outq.sv]
// Four-entry result queue that takes up to two results per cycle and gives one.
module cft_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cft_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             pop_i,
  output cft_pkg::result_t head_o
);
  import cft_pkg::*;

  result_t               mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OQ_CNT_W-1:0]   count_q;
  logic                  pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = count_q != '0;
  assign room_o  = count_q <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + OQ_PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_i.n);
      rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(pop);
      count_q  <= count_q + OQ_CNT_W'(push_i.n) - OQ_CNT_W'(pop);
    end
  end

endmodule

[sv/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: byte stream in, field tokens out.
//
//   channel   direction  fields
//   s_axis    in         tdata[7:0] in_byte, tuser[0] end_of_input
//   m_axis    out        tdata[7:0] out_byte, tuser[2:0] kind, tlast last
//   cfg       in         data[7:0] separator
//
// One input byte is taken per cycle while the result queue has room for two results.
// The tokenizer state updates in the cycle of the transfer; results go through the queue.
// Output runs at one result per cycle while m_axis is ready; two-result bytes slow intake.
// Reset clears the quote state and the queue and sets the separator to a comma.
// A stall on m_axis lets the four-entry queue fill; s_axis_tready_o drops once three
// results wait.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,   // [2:0] kind
  output logic       m_axis_tlast_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i        // [7:0] separator
);
  import cft_pkg::*;

  logic [7:0] sep_q;
  qmode_e     qm_q;
  logic       cont_q, lhb_q, crh_q;

  logic       xfer, room, eoi, done, hold_cr, use2, ev1, ev2, e_ev;
  logic [7:0] b;
  qmode_e     qm_norm;
  tok_state_t s0, s1, st_d;
  take_res_t  res1, res2;
  result_t    q1, q2, head;
  push_t      push;
  kind_e      e_kind;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = room;
  assign xfer            = s_axis_tvalid_i && room;
  assign b               = s_axis_tdata_i;
  assign eoi             = s_axis_tuser_i;

  always_comb begin
    qm_norm = (qm_q == Q_IN || qm_q == Q_HELD) ? qm_q : Q_OUT;
    s0      = '{qm: qm_norm, cont: cont_q, lhb: lhb_q};
    done    = crh_q && (b == CH_LF);
    // A held carriage return is either folded into the newline or replayed as a byte.
    res1    = take_byte(s0, done ? CH_LF : CH_CR, sep_q);
    s1      = crh_q ? res1.st : s0;
    hold_cr = !done && s1.cont && (b == CH_CR);
    use2    = !done && !hold_cr;
    res2    = take_byte(s1, b, sep_q);

    e_ev   = (qm_norm == Q_IN) || lhb_q || cont_q;
    e_kind = (qm_norm == Q_IN) ? KIND_ERR : KIND_EOR;

    if (eoi) begin
      st_d = '{qm: Q_OUT, cont: 1'b0, lhb: 1'b0};
    end else if (use2) begin
      st_d = res2.st;
    end else begin
      st_d = s1;
      if (hold_cr && s1.qm == Q_HELD) begin
        st_d.qm = Q_OUT;
      end
    end

    ev1 = eoi ? e_ev : (crh_q && res1.ev);
    ev2 = !eoi && use2 && res2.ev;

    q1 = '{kind: eoi ? e_kind : res1.kind, data: eoi ? 8'h00 : res1.data, last: 1'b0};
    q2 = '{kind: res2.kind, data: res2.data, last: 1'b1};
    q1.last = !ev2;

    push.r0 = ev1 ? q1 : q2;
    push.r1 = q2;
    push.n  = xfer ? (2'(ev1) + 2'(ev2)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q  <= SEP_RESET;
      qm_q   <= Q_OUT;
      cont_q <= 1'b0;
      lhb_q  <= 1'b0;
      crh_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        sep_q <= cfg_data_i;
      end
      if (xfer) begin
        qm_q   <= st_d.qm;
        cont_q <= st_d.cont;
        lhb_q  <= st_d.lhb;
        crh_q  <= !eoi && hold_cr;
      end
    end
  end

  cft_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = head.data;
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

[sv/cft_checker.sv]
// Port-level checks for the CSV field tokenizer, bound to the top level.
module cft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);
  import cft_pkg::*;

  // A result that waits on the sink keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= KIND_ERR)
    else $error("result kind out of range");

  // Only data results carry a byte.
  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_DATA |-> m_axis_tdata_o == 8'h00)
    else $error("marker result carries a byte");

  // Record ends and the quote error are always the final result of their byte.
  a_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_EOR || m_axis_tuser_o == KIND_EMPTY
      || m_axis_tuser_o == KIND_ERR) |-> m_axis_tlast_o)
    else $error("record mark without tlast");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);
